// ===== hdl/rysub_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, register map and fixed-point constants for the RGB/YUV
// chroma subsampling round trip. No dependencies.
package rysub_pkg;

	localparam int MAX_WIDTH_DEF = 512;
	localparam int MAX_HEIGHT    = 4096;
	localparam int ADDR_W        = 4;

	// Register indexes (byte address = 4 * index)
	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;

	// Subsample modes
	localparam logic [1:0] MODE_NONE = 2'd0;
	localparam logic [1:0] MODE_411  = 2'd1;
	localparam logic [1:0] MODE_422  = 2'd2;
	localparam logic [1:0] MODE_420  = 2'd3;

	// Q16 coefficients, forward transform
	localparam logic signed [31:0] C_YR = 32'sd19655;
	localparam logic signed [31:0] C_YG = 32'sd38470;
	localparam logic signed [31:0] C_YB = 32'sd7471;
	localparam logic signed [31:0] C_UR = -32'sd11058;
	localparam logic signed [31:0] C_UG = -32'sd21710;
	localparam logic signed [31:0] C_UB = 32'sd32768;
	localparam logic signed [31:0] C_VR = 32'sd32768;
	localparam logic signed [31:0] C_VG = -32'sd27439;
	localparam logic signed [31:0] C_VB = -32'sd5329;
	localparam logic signed [31:0] C_OFS = 32'sd8388608;
	// Q16 coefficients, inverse transform
	localparam logic signed [31:0] C_RV = 32'sd91888;
	localparam logic signed [31:0] C_GU = -32'sd22554;
	localparam logic signed [31:0] C_GV = -32'sd46802;
	localparam logic signed [31:0] C_BU = 32'sd116117;

	typedef struct packed {
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} in_beat_t;

	typedef struct packed {
		logic [11:0] pixel_row;
		logic [8:0]  pixel_col;
		logic [7:0]  luma_out;
		logic [7:0]  cb_out;
		logic [7:0]  cr_out;
		logic [7:0]  red_out;
		logic [7:0]  green_out;
		logic [7:0]  blue_out;
		logic        group_last;
	} out_beat_t;

	typedef struct packed {
		logic [7:0] y;
		logic [7:0] u;
		logic [7:0] v;
	} yuv_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic conv;
		logic store;
		logic mx_rd;
		logic mx_acc;
		logic e_rd;
		logic e_calc;
		logic e_next;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic close;
		logic mx_last;
		logic e_last;
	} sts_t;

	// Negative gives 0, else drop the fraction and saturate at 255
	function automatic logic [7:0] sat_q16(input logic signed [31:0] s);
		logic [7:0] r;
		if (s < 0) begin
			r = 8'd0;
		end else if (s[31:16] > 16'd255) begin
			r = 8'd255;
		end else begin
			r = s[23:16];
		end
		return r;
	endfunction

endpackage

// ===== hdl/rgb_yuv_chroma_subsample_roundtrip.sv =====
`timescale 1ns / 1ps
// RGB -> YUV -> RGB round trip with chroma subsampling, top level.
// Holds the APB register file; depends on rysub_pkg, rysub_ctrl, rysub_dp.
//
// Usage: RGB pixels enter in raster order on in_valid/in_ready/in_data, one
// beat per pixel. Results leave on out_valid/out_ready/out_data, one beat per
// pixel, carrying row, column, Y, the group's maximum Cb/Cr and the
// reconstructed RGB; group_last marks the final beat caused by one input.
// Registers (APB, byte address 4*i): mode, image width, image height; any
// write restarts the frame at row 0, column 0. Write only while idle.
// Sequence: an input that does not close a group is converted and stored,
// then the next beat is taken. One that closes a group of n stored pixels
// (upper and lower rows counted) runs a max pass, a read and an accumulate
// step per column of the group, then a read, compute and wait step per
// result beat, held while the receiver stalls. Row store reads are registered.
// Reset clears the counters and registers to mode none, 512 x 512; store
// contents are not cleared. When out_ready is low the current result beat
// holds and no new input is taken.
module rgb_yuv_chroma_subsample_roundtrip #(
	parameter int MAX_WIDTH = rysub_pkg::MAX_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  rysub_pkg::in_beat_t             in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output rysub_pkg::out_beat_t            out_data,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [rysub_pkg::ADDR_W-1:0]    paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);

	logic [1:0]  mode_q;
	logic [9:0]  width_q;
	logic [12:0] height_q;
	logic        wr_en;
	logic [1:0]  reg_idx;
	rysub_pkg::cmd_t cmd;
	rysub_pkg::sts_t sts;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= rysub_pkg::MODE_NONE;
			width_q  <= 10'd512;
			height_q <= 13'd512;
		end else if (wr_en) begin
			case (reg_idx)
				rysub_pkg::REG_MODE:   mode_q   <= pwdata[1:0];
				rysub_pkg::REG_WIDTH:  width_q  <= pwdata[9:0];
				rysub_pkg::REG_HEIGHT: height_q <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (reg_idx)
			rysub_pkg::REG_MODE:   prdata = {30'd0, mode_q};
			rysub_pkg::REG_WIDTH:  prdata = {22'd0, width_q};
			rysub_pkg::REG_HEIGHT: prdata = {19'd0, height_q};
			default:               prdata = 32'd0;
		endcase
	end

	rysub_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rysub_dp #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.restart      (wr_en),
		.mode         (mode_q),
		.image_width  (width_q),
		.image_height (height_q),
		.in_data      (in_data),
		.cmd          (cmd),
		.sts          (sts),
		.out_data     (out_data)
	);

endmodule

// ===== hdl/rysub_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences accept, conversion, store, chroma max pass and
// result emission. Depends on rysub_pkg.
module rysub_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  rysub_pkg::sts_t   sts,
	output rysub_pkg::cmd_t   cmd
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_CONV, ST_STORE, ST_MX_RD, ST_MX_ACC, ST_E_RD, ST_E_CALC, ST_E_WAIT
	} state_t;

	state_t state_q;
	logic   in_ready_q;
	logic   out_valid_q;

	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;

	// Decode commands from the current state
	always_comb begin
		cmd        = '0;
		cmd.load   = (state_q == ST_IDLE) && in_valid && in_ready_q;
		cmd.conv   = (state_q == ST_CONV);
		cmd.store  = (state_q == ST_STORE);
		cmd.mx_rd  = (state_q == ST_MX_RD);
		cmd.mx_acc = (state_q == ST_MX_ACC);
		cmd.e_rd   = (state_q == ST_E_RD);
		cmd.e_calc = (state_q == ST_E_CALC);
		cmd.e_next = (state_q == ST_E_WAIT) && out_ready;
	end

	// Advance state and registered handshake outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready_q) begin
						in_ready_q <= 1'b0;
						state_q    <= ST_CONV;
					end
				end
				ST_CONV: state_q <= ST_STORE;
				ST_STORE: begin
					if (sts.close) begin
						state_q <= ST_MX_RD;
					end else begin
						in_ready_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				ST_MX_RD: state_q <= ST_MX_ACC;
				ST_MX_ACC: begin
					state_q <= sts.mx_last ? ST_E_RD : ST_MX_RD;
				end
				ST_E_RD: state_q <= ST_E_CALC;
				ST_E_CALC: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_E_WAIT;
				end
				ST_E_WAIT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						if (sts.e_last) begin
							in_ready_q <= 1'b1;
							state_q    <= ST_IDLE;
						end else begin
							state_q <= ST_E_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== hdl/rysub_dp.sv =====
`timescale 1ns / 1ps
// Datapath: color conversion, raster counters, row and group stores,
// chroma max and reconstruction. Depends on rysub_pkg.
module rysub_dp #(
	parameter int MAX_WIDTH = rysub_pkg::MAX_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 restart,
	input  logic [1:0]           mode,
	input  logic [9:0]           image_width,
	input  logic [12:0]          image_height,
	input  rysub_pkg::in_beat_t  in_data,
	input  rysub_pkg::cmd_t      cmd,
	output rysub_pkg::sts_t      sts,
	output rysub_pkg::out_beat_t out_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);

	// Row store and its registered read port
	logic [23:0] row_mem [MAX_WIDTH];
	rysub_pkg::yuv_t rd_q;
	logic [CW-1:0]   rd_addr;

	rysub_pkg::yuv_t grp_q [4];
	rysub_pkg::in_beat_t rgb_q;
	rysub_pkg::yuv_t pix_q;

	logic [CW-1:0] col_q;
	logic [11:0]   row_q;

	// Group context, latched at store
	logic [CW-1:0] start_q;
	logic [1:0]    cnt_m1_q;
	logic [11:0]   grow_q;
	logic          two_q;
	logic [1:0]    idx_q;
	logic [2:0]    k_q;
	logic [7:0]    um_q;
	logic [7:0]    vm_q;
	rysub_pkg::out_beat_t out_q;

	// Frame geometry
	logic [WW-1:0] w_eff;
	logic [12:0]   h_eff;
	logic          col_last, row_last;
	logic [1:0]    pos, gm1;
	logic          hold_row, two_rows;

	always_comb begin
		if (image_width == 10'd0) begin
			w_eff = WW'(1);
		end else if (32'(image_width) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(image_width);
		end
		if (image_height == 13'd0) begin
			h_eff = 13'd1;
		end else if (image_height > 13'(rysub_pkg::MAX_HEIGHT)) begin
			h_eff = 13'(rysub_pkg::MAX_HEIGHT);
		end else begin
			h_eff = image_height;
		end
		col_last = (WW'(col_q) == w_eff - WW'(1));
		row_last = ({1'b0, row_q} == h_eff - 13'd1);
		case (mode)
			rysub_pkg::MODE_NONE: begin pos = 2'd0; gm1 = 2'd0; end
			rysub_pkg::MODE_411:  begin pos = col_q[1:0]; gm1 = 2'd3; end
			rysub_pkg::MODE_422:  begin pos = {1'b0, col_q[0]}; gm1 = 2'd1; end
			default:              begin pos = {1'b0, col_q[0]}; gm1 = 2'd1; end
		endcase
		two_rows = (mode == rysub_pkg::MODE_420) && row_q[0];
		hold_row = (mode == rysub_pkg::MODE_420) && !row_q[0] && !row_last;
	end

	assign sts.close = !hold_row && ((pos == gm1) || col_last);
	assign sts.mx_last = (idx_q == cnt_m1_q);

	// Emission item selection
	logic [2:0] tot_m1, gi3;
	logic       row_item;
	assign tot_m1   = two_q ? {cnt_m1_q, 1'b1} : {1'b0, cnt_m1_q};
	assign row_item = two_q && (k_q <= {1'b0, cnt_m1_q});
	assign gi3      = two_q ? (k_q - ({1'b0, cnt_m1_q} + 3'd1)) : k_q;
	assign sts.e_last = (k_q == tot_m1);

	always_comb begin
		if (cmd.mx_rd) begin
			rd_addr = start_q + CW'(idx_q);
		end else begin
			rd_addr = start_q + CW'(k_q[1:0]);
		end
	end

	// Forward transform of the latched pixel
	logic signed [31:0] rs, gs, bs;
	rysub_pkg::yuv_t yuv_new;
	assign rs = $signed({24'd0, rgb_q.red_in});
	assign gs = $signed({24'd0, rgb_q.green_in});
	assign bs = $signed({24'd0, rgb_q.blue_in});
	assign yuv_new.y = rysub_pkg::sat_q16(rysub_pkg::C_YR * rs + rysub_pkg::C_YG * gs
		+ rysub_pkg::C_YB * bs);
	assign yuv_new.u = rysub_pkg::sat_q16(rysub_pkg::C_UR * rs + rysub_pkg::C_UG * gs
		+ rysub_pkg::C_UB * bs + rysub_pkg::C_OFS);
	assign yuv_new.v = rysub_pkg::sat_q16(rysub_pkg::C_VR * rs + rysub_pkg::C_VG * gs
		+ rysub_pkg::C_VB * bs + rysub_pkg::C_OFS);

	// Inverse transform of the selected pixel
	rysub_pkg::yuv_t sel_pix;
	logic signed [31:0] yq, du, dv;
	assign sel_pix = row_item ? rd_q : grp_q[gi3[1:0]];
	assign yq = $signed({8'd0, sel_pix.y, 16'd0});
	assign du = $signed({24'd0, um_q}) - 32'sd128;
	assign dv = $signed({24'd0, vm_q}) - 32'sd128;

	// Max pass candidates
	rysub_pkg::yuv_t gcur;
	logic [7:0] um_n, vm_n;
	always_comb begin
		gcur = grp_q[idx_q];
		um_n = (gcur.u > um_q) ? gcur.u : um_q;
		vm_n = (gcur.v > vm_q) ? gcur.v : vm_q;
		if (two_q && (rd_q.u > um_n)) um_n = rd_q.u;
		if (two_q && (rd_q.v > vm_n)) vm_n = rd_q.v;
	end

	// Write and read the row store
	always_ff @(posedge clk) begin
		if (cmd.store && hold_row) row_mem[col_q] <= pix_q;
	end
	always_ff @(posedge clk) begin
		if (cmd.mx_rd || cmd.e_rd) rd_q <= row_mem[rd_addr];
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) rgb_q <= in_data;
		if (cmd.conv) pix_q <= yuv_new;
		if (cmd.store && !hold_row) grp_q[pos] <= pix_q;
		if (cmd.store) begin
			start_q  <= col_q - CW'(pos);
			cnt_m1_q <= pos;
			grow_q   <= row_q;
			two_q    <= two_rows;
			um_q     <= 8'd0;
			vm_q     <= 8'd0;
		end
		if (cmd.mx_acc) begin
			um_q <= um_n;
			vm_q <= vm_n;
		end
		if (cmd.e_calc) begin
			out_q.pixel_row  <= row_item ? grow_q - 12'd1 : grow_q;
			out_q.pixel_col  <= 9'(start_q + CW'(row_item ? k_q[1:0] : gi3[1:0]));
			out_q.luma_out   <= sel_pix.y;
			out_q.cb_out     <= um_q;
			out_q.cr_out     <= vm_q;
			out_q.red_out    <= rysub_pkg::sat_q16(yq + rysub_pkg::C_RV * dv);
			out_q.green_out  <= rysub_pkg::sat_q16(yq + rysub_pkg::C_GU * du
				+ rysub_pkg::C_GV * dv);
			out_q.blue_out   <= rysub_pkg::sat_q16(yq + rysub_pkg::C_BU * du);
			out_q.group_last <= sts.e_last;
		end
	end
	assign out_data = out_q;

	// Raster counters and pass indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			idx_q <= '0;
			k_q   <= '0;
		end else begin
			if (restart) begin
				col_q <= '0;
				row_q <= '0;
			end else if (cmd.store) begin
				if (col_last) begin
					col_q <= '0;
					row_q <= row_last ? 12'd0 : row_q + 12'd1;
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
			if (cmd.store) begin
				idx_q <= '0;
				k_q   <= '0;
			end
			if (cmd.mx_acc) idx_q <= idx_q + 2'd1;
			if (cmd.e_next) k_q <= k_q + 3'd1;
		end
	end

endmodule
